/* hdl/hrsa_pkg.sv */
// Shared types, widths and constants for the hashed register slot allocator.
// No dependencies; all files but hrsa_ram refer to it by scoped names.
package hrsa_pkg;

  localparam int SLOT_COUNT_DEF  = 256;
  localparam int LOWER_LIMIT_DEF = 128;
  localparam int PIXEL_TOP_DEF   = 224;

  localparam int HASH_W  = 32;
  localparam int TYPE_W  = 3;
  localparam int COUNT_W = 8;
  localparam int SLOT_W  = 8;
  localparam int LEN_W   = 10;
  localparam int FACT_W  = 3;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam logic REG_VERTEX_MODE = 1'b0;

  localparam logic [FACT_W-1:0] ELEM_FACTOR [0:7] = '{
    3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd4, 3'd0
  };

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

endpackage

/* hdl/hashed_register_slot_allocator.sv */
// Top level of the hashed register slot allocator: sequencer, config register.
// Depends on hrsa_pkg, hrsa_ram (occupancy bitmap) and hrsa_mod_unit.
//
// After reset the block sweeps the occupancy RAM clear, one slot a cycle, and
// holds busy high until the sweep is done. A request is taken when start is
// high and busy low; its single result is strobed on out_valid for one cycle,
// which the receiver must take as it comes. A request that allocates nothing
// or does not fit its window answers in the cycle after it is taken and never
// raises busy. Any other request holds busy high until its result is strobed:
// first the remainder unit (one bit a cycle), then a scan of the window one
// slot a cycle through the RAM read port, then marking of the run one slot a
// cycle through the write port.
module hashed_register_slot_allocator #(
  parameter int SLOT_COUNT  = hrsa_pkg::SLOT_COUNT_DEF,
  parameter int LOWER_LIMIT = hrsa_pkg::LOWER_LIMIT_DEF,
  parameter int PIXEL_TOP   = hrsa_pkg::PIXEL_TOP_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [hrsa_pkg::HASH_W-1:0]  in_name_hash,
  input  logic [hrsa_pkg::TYPE_W-1:0]  in_type_code,
  input  logic [hrsa_pkg::COUNT_W-1:0] in_array_count,
  output logic                         out_valid,
  output logic [hrsa_pkg::SLOT_W-1:0]  out_slot_index,
  output logic [1:0]                   out_status,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hrsa_pkg::ADDR_W-1:0]  paddr,
  input  logic [hrsa_pkg::DATA_W-1:0]  pwdata,
  output logic [hrsa_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int AW  = $clog2(SLOT_COUNT);
  localparam int DW  = AW + 1;
  localparam int PW  = ((AW + 2) > (hrsa_pkg::LEN_W + 1)) ? (AW + 2) : (hrsa_pkg::LEN_W + 1);
  localparam int VW  = PW + 1;
  localparam int LOWER_CLIP = (LOWER_LIMIT > SLOT_COUNT) ? SLOT_COUNT : LOWER_LIMIT;
  localparam int TOP_V      = SLOT_COUNT;
  localparam int TOP_P      = (PIXEL_TOP > SLOT_COUNT) ? SLOT_COUNT : PIXEL_TOP;

  typedef logic signed [VW-1:0] pos_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_MARK
  } state_t;

  state_t                      state_r;
  logic                        vertex_mode_r;
  logic [AW-1:0]               clr_addr_r;
  pos_t                        lo_r;
  pos_t                        last_r;
  pos_t                        len_r;
  logic [DW-1:0]               span_r;
  pos_t                        scan_addr_r;
  pos_t                        pend_addr_r;
  logic                        pend_v_r;
  pos_t                        seg_end_r;
  pos_t                        seg2_end_r;
  logic                        seg2_en_r;
  pos_t                        run_r;
  pos_t                        mark_addr_r;
  pos_t                        mark_cnt_r;
  logic                        out_valid_r;
  logic [hrsa_pkg::SLOT_W-1:0] slot_out_r;
  hrsa_pkg::status_t           status_r;

  logic [hrsa_pkg::FACT_W-1:0] factor;
  logic [hrsa_pkg::LEN_W-1:0]  len_c;
  logic                        upper;
  pos_t                        lo_c;
  pos_t                        top_c;
  pos_t                        len_s;
  pos_t                        last_c;
  pos_t                        span_c;
  logic                        accept;
  logic                        zero_len;
  logic                        too_large;

  logic                        div_start;
  logic                        div_done;
  logic [DW-1:0]               div_rem;
  pos_t                        pos0_c;
  logic                        at_last;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [0:0]                  ram_wdata;
  logic [0:0]                  ram_rdata;
  logic                        slot_free;
  pos_t                        run_inc;
  logic                        hit;
  pos_t                        cand;
  logic                        cfg_wr;

  always_comb begin
    factor    = hrsa_pkg::ELEM_FACTOR[in_type_code];
    len_c     = {{(hrsa_pkg::LEN_W - hrsa_pkg::FACT_W){1'b0}}, factor}
              * {{(hrsa_pkg::LEN_W - hrsa_pkg::COUNT_W){1'b0}}, in_array_count};
    upper     = in_array_count > hrsa_pkg::COUNT_W'(1);
    lo_c      = upper ? pos_t'(LOWER_CLIP) : pos_t'(0);
    top_c     = upper ? (vertex_mode_r ? pos_t'(TOP_V) : pos_t'(TOP_P)) : pos_t'(LOWER_CLIP);
    len_s     = pos_t'(len_c);
    last_c    = top_c - len_s;
    span_c    = last_c - lo_c + pos_t'(1);
    accept    = start && (state_r == S_IDLE);
    zero_len  = (len_c == '0);
    too_large = (last_c < lo_c);
    div_start = accept && !zero_len && !too_large;
  end

  always_comb begin
    pos0_c  = lo_r + pos_t'(div_rem);
    at_last = (pos0_c == last_r);
  end

  always_comb begin
    slot_free = !ram_rdata[0];
    run_inc   = run_r + pos_t'(1);
    hit       = pend_v_r && slot_free && (run_inc >= len_r);
    cand      = pend_addr_r - len_r + pos_t'(1);
  end

  always_comb begin
    ram_we    = (state_r == S_CLEAR) || (state_r == S_MARK);
    ram_waddr = (state_r == S_CLEAR) ? clr_addr_r : mark_addr_r[AW-1:0];
    ram_wdata = (state_r == S_MARK) ? 1'b1 : 1'b0;
  end

  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      vertex_mode_r <= 1'b1;
      clr_addr_r    <= '0;
      pend_v_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_wr && (paddr[2] == hrsa_pkg::REG_VERTEX_MODE)) begin
        vertex_mode_r <= pwdata[0];
      end
      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(SLOT_COUNT - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            lo_r   <= lo_c;
            last_r <= last_c;
            len_r  <= len_s;
            span_r <= span_c[DW-1:0];
            if (zero_len) begin
              out_valid_r <= 1'b1;
              slot_out_r  <= '0;
              status_r    <= hrsa_pkg::ST_OK;
            end else if (too_large) begin
              out_valid_r <= 1'b1;
              slot_out_r  <= '0;
              status_r    <= hrsa_pkg::ST_TOO_LARGE;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            scan_addr_r <= pos0_c;
            seg_end_r   <= (at_last ? last_r : last_r - pos_t'(1)) + len_r - pos_t'(1);
            seg2_end_r  <= (at_last ? last_r - pos_t'(1) : pos0_c) + len_r - pos_t'(1);
            seg2_en_r   <= !(at_last && (last_r == lo_r));
            run_r       <= '0;
            pend_v_r    <= 1'b0;
            state_r     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            mark_addr_r <= cand;
            mark_cnt_r  <= len_r;
            slot_out_r  <= hrsa_pkg::SLOT_W'(cand);
            pend_v_r    <= 1'b0;
            state_r     <= S_MARK;
          end else if (pend_v_r && (pend_addr_r == seg_end_r)) begin
            pend_v_r <= 1'b0;
            if (seg2_en_r) begin
              scan_addr_r <= lo_r;
              seg_end_r   <= seg2_end_r;
              seg2_en_r   <= 1'b0;
              run_r       <= '0;
            end else begin
              out_valid_r <= 1'b1;
              slot_out_r  <= '0;
              status_r    <= hrsa_pkg::ST_FULL;
              state_r     <= S_IDLE;
            end
          end else begin
            scan_addr_r <= scan_addr_r + pos_t'(1);
            pend_addr_r <= scan_addr_r;
            pend_v_r    <= 1'b1;
            if (pend_v_r) begin
              run_r <= slot_free ? run_inc : pos_t'(0);
            end
          end
        end
        S_MARK: begin
          mark_addr_r <= mark_addr_r + pos_t'(1);
          mark_cnt_r  <= mark_cnt_r - pos_t'(1);
          if (mark_cnt_r == pos_t'(1)) begin
            out_valid_r <= 1'b1;
            status_r    <= hrsa_pkg::ST_OK;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  hrsa_ram #(
    .WIDTH (1),
    .DEPTH (SLOT_COUNT)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_addr_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  hrsa_mod_unit #(
    .DIV_W (DW)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (in_name_hash),
    .divisor   (span_c[DW-1:0]),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_slot_index = slot_out_r;
  assign out_status     = status_r;
  assign prdata         = (paddr[2] == hrsa_pkg::REG_VERTEX_MODE)
                        ? {{(hrsa_pkg::DATA_W - 1){1'b0}}, vertex_mode_r} : '0;
  assign pready         = 1'b1;

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result strobe without a request in flight");

  a_error_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != hrsa_pkg::ST_OK)) |-> (out_slot_index == '0))
    else $error("failed request reports a non-zero slot");

  a_mark_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARK) |-> ((mark_addr_r >= lo_r) && (mark_addr_r < last_r + len_r)))
    else $error("marking outside the request window");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("remainder ready outside the divide step");

  a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (div_rem < span_r))
    else $error("remainder not below window span");

endmodule

/* hdl/hrsa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hrsa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/hrsa_mod_unit.sv */
// Iterative remainder unit: one restoring subtract step per cycle.
// Depends on hrsa_pkg for the dividend width.
module hrsa_mod_unit #(
  parameter int DIV_W = 9
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [hrsa_pkg::HASH_W-1:0] dividend,
  input  logic [DIV_W-1:0]          divisor,
  output logic                      done,
  output logic [DIV_W-1:0]          remainder
);

  localparam int CNT_W = $clog2(hrsa_pkg::HASH_W);

  logic                        run_r;
  logic                        done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [hrsa_pkg::HASH_W-1:0] dvd_r;
  logic [DIV_W-1:0]            dsr_r;
  logic [DIV_W-1:0]            rem_r;
  logic [DIV_W:0]              trial;
  logic [DIV_W:0]              diff;
  logic [DIV_W-1:0]            rem_nxt;

  always_comb begin
    trial   = {rem_r, dvd_r[hrsa_pkg::HASH_W-1]};
    diff    = trial - {1'b0, dsr_r};
    rem_nxt = (trial >= {1'b0, dsr_r}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= '0;
        dvd_r <= dividend;
        dsr_r <= divisor;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= rem_nxt;
        dvd_r <= dvd_r << 1;
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(hrsa_pkg::HASH_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

/* tb/hashed_register_slot_allocator_test.sv */
// Self-checking testbench for hashed_register_slot_allocator: a queue-fed request driver,
// an edge-sampled monitor with its own slot-occupancy predictor, and APB mode writes.
// Depends on hrsa_pkg and the RTL of hashed_register_slot_allocator only.
module hashed_register_slot_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [hrsa_pkg::HASH_W-1:0]  hash;
    logic [hrsa_pkg::TYPE_W-1:0]  tcode;
    logic [hrsa_pkg::COUNT_W-1:0] cnt;
  } alloc_request_t;

  typedef struct {
    logic [hrsa_pkg::SLOT_W-1:0] slot;
    hrsa_pkg::status_t           status;
  } alloc_result_t;

  localparam int UNIT_SLOTS [0:7] = '{0, 0, 1, 1, 1, 1, 4, 0};
  localparam logic [hrsa_pkg::ADDR_W-1:0] VERTEX_MODE_ADDR =
    hrsa_pkg::ADDR_W'(4 * int'(hrsa_pkg::REG_VERTEX_MODE));

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [hrsa_pkg::HASH_W-1:0]   in_name_hash = '0;
  logic [hrsa_pkg::TYPE_W-1:0]   in_type_code = '0;
  logic [hrsa_pkg::COUNT_W-1:0]  in_array_count = '0;
  logic                          out_valid;
  logic [hrsa_pkg::SLOT_W-1:0]   out_slot_index;
  logic [1:0]                    out_status;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [hrsa_pkg::ADDR_W-1:0]   paddr = '0;
  logic [hrsa_pkg::DATA_W-1:0]   pwdata = '0;
  logic [hrsa_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  alloc_request_t pending_requests [$];
  alloc_result_t  expected_allocs [$];
  bit             slot_map [0:hrsa_pkg::SLOT_COUNT_DEF-1];
  logic           vertex_mode_copy = 1'b1;
  logic           took_request = 1'b0;
  int             mismatches = 0;
  int             burst_left = 8;
  int             gap_left = 0;

  hashed_register_slot_allocator u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_name_hash(in_name_hash), .in_type_code(in_type_code),
    .in_array_count(in_array_count), .out_valid(out_valid),
    .out_slot_index(out_slot_index), .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  function automatic alloc_result_t predict_allocation(
    logic [hrsa_pkg::HASH_W-1:0] hash,
    logic [hrsa_pkg::TYPE_W-1:0] tcode,
    logic [hrsa_pkg::COUNT_W-1:0] cnt);
    alloc_result_t r;
    int len, lo, top, last, span, pos;
    bit fits;
    r.slot = '0;
    r.status = hrsa_pkg::ST_OK;
    len = UNIT_SLOTS[tcode] * int'(cnt);
    if (len == 0) return r;
    if (cnt <= 1) begin
      lo = 0;
      top = hrsa_pkg::LOWER_LIMIT_DEF;
    end else begin
      lo = hrsa_pkg::LOWER_LIMIT_DEF;
      top = vertex_mode_copy ? hrsa_pkg::SLOT_COUNT_DEF : hrsa_pkg::PIXEL_TOP_DEF;
    end
    last = top - len;
    if (last < lo) begin
      r.status = hrsa_pkg::ST_TOO_LARGE;
      return r;
    end
    span = last - lo + 1;
    pos = lo + int'(hash % 32'(span));
    for (int n = 0; n < span; n++) begin
      fits = 1'b1;
      for (int i = 0; i < len; i++)
        if (slot_map[pos + i]) fits = 1'b0;
      if (fits) begin
        for (int i = 0; i < len; i++) slot_map[pos + i] = 1'b1;
        r.slot = hrsa_pkg::SLOT_W'(pos);
        return r;
      end
      pos = (pos + 1 >= last) ? lo : pos + 1;
    end
    r.status = hrsa_pkg::ST_FULL;
    return r;
  endfunction

  always @(negedge clk) begin
    alloc_request_t req;
    if (rst_n) begin
      if (start && !took_request) begin
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (pending_requests.size() > 0) begin
        req = pending_requests.pop_front();
        in_name_hash <= req.hash;
        in_type_code <= req.tcode;
        in_array_count <= req.cnt;
        start <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 3))
            0: gap_left = $urandom_range(1, 3);
            1: gap_left = $urandom_range(4, 40);
            default: gap_left = 0;
          endcase
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    alloc_result_t want;
    alloc_result_t pred;
    if (!rst_n) begin
      took_request <= 1'b0;
      vertex_mode_copy <= 1'b1;
      for (int i = 0; i < hrsa_pkg::SLOT_COUNT_DEF; i++) slot_map[i] = 1'b0;
    end else begin
      took_request <= start && !busy;
      if (psel && penable && pwrite && pready && paddr == VERTEX_MODE_ADDR)
        vertex_mode_copy <= pwdata[0];
      if (out_valid) begin
        if (expected_allocs.size() == 0) begin
          report($sformatf("unexpected result slot %0d status %0d",
                           out_slot_index, out_status));
        end else begin
          want = expected_allocs.pop_front();
          if (out_slot_index !== want.slot || out_status !== want.status)
            report($sformatf("slot exp %0d got %0d, status exp %0d got %0d",
                             want.slot, out_slot_index, want.status, out_status));
        end
      end
      if (start && !busy) begin
        pred = predict_allocation(in_name_hash, in_type_code, in_array_count);
        expected_allocs = {expected_allocs, pred};
      end
    end
  end

  task automatic cfg_write(input logic [hrsa_pkg::DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= VERTEX_MODE_ADDR;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic cfg_read_check(input logic [hrsa_pkg::DATA_W-1:0] want);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= VERTEX_MODE_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      report($sformatf("vertex_mode read exp %0h got %0h", want, prdata));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_request(input logic [hrsa_pkg::HASH_W-1:0] hash,
                              input logic [hrsa_pkg::TYPE_W-1:0] tcode,
                              input logic [hrsa_pkg::COUNT_W-1:0] cnt);
    alloc_request_t req;
    req.hash = hash;
    req.tcode = tcode;
    req.cnt = cnt;
    pending_requests = {pending_requests, req};
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || start || expected_allocs.size() != 0 || busy)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic random_requests(input int n);
    logic [hrsa_pkg::HASH_W-1:0] hash;
    for (int k = 0; k < n; k++) begin
      hash = ($urandom_range(0, 3) == 0) ? hrsa_pkg::HASH_W'($urandom_range(0, 300))
                                         : $urandom();
      case ($urandom_range(0, 19))
        0, 1:
          send_request(hash,
                       hrsa_pkg::TYPE_W'($urandom_range(0, 1) ? 7 : $urandom_range(0, 1)),
                       hrsa_pkg::COUNT_W'($urandom()));
        2:
          send_request(hash, hrsa_pkg::TYPE_W'($urandom()), '0);
        3, 4, 5, 6, 7, 8, 9, 10:
          send_request(hash, hrsa_pkg::TYPE_W'($urandom_range(2, 6)), 8'd1);
        11, 12, 13, 14, 15:
          send_request(hash, hrsa_pkg::TYPE_W'($urandom_range(2, 6)),
                       hrsa_pkg::COUNT_W'($urandom_range(2, 6)));
        16, 17:
          send_request(hash, hrsa_pkg::TYPE_W'($urandom_range(2, 6)),
                       hrsa_pkg::COUNT_W'($urandom_range(7, 255)));
        default:
          send_request($urandom(), hrsa_pkg::TYPE_W'($urandom()),
                       hrsa_pkg::COUNT_W'($urandom()));
      endcase
    end
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait_idle();
    cfg_read_check(32'd1);
    cfg_write(32'd0);
    cfg_read_check(32'd0);

    send_request(32'h0000_0000, 3'd0, 8'd0);
    send_request(32'hFFFF_FFFF, 3'd1, 8'd255);
    send_request(32'h0000_1234, 3'd7, 8'd9);
    send_request(32'h0000_0005, 3'd2, 8'd0);
    send_request(32'hFFFF_FFFF, 3'd6, 8'd0);
    send_request(32'h0000_0000, 3'd2, 8'd1);
    send_request(32'hFFFF_FFFF, 3'd3, 8'd1);
    send_request(32'h0000_0000, 3'd2, 8'd1);
    send_request(32'h0000_007F, 3'd6, 8'd1);
    send_request(32'h0000_007E, 3'd5, 8'd1);
    send_request(32'h0000_007B, 3'd4, 8'd1);
    send_request(32'h0000_007F, 3'd2, 8'd1);
    send_request(32'h0000_007F, 3'd3, 8'd1);
    send_request(32'h0000_0000, 3'd2, 8'd2);
    send_request(32'hFFFF_FFFF, 3'd6, 8'd2);
    send_request(32'h0000_005F, 3'd3, 8'd3);
    send_request(32'h0000_0000, 3'd6, 8'd24);
    send_request(32'h0000_0000, 3'd6, 8'd25);
    send_request(32'h0000_0007, 3'd2, 8'd255);
    send_request(32'h0000_0009, 3'd5, 8'd96);
    send_request(32'h0000_0003, 3'd4, 8'd97);
    send_request(32'h8000_0000, 3'd7, 8'd255);
    wait_idle();

    cfg_write(32'd1);
    cfg_read_check(32'd1);
    random_requests(390);
    cfg_write(32'd0);
    random_requests(390);
    cfg_write(32'd1);
    random_requests(390);
    repeat (100) @(negedge clk);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
